[rtl/core/page_bitmap_allocator_assert.svh]
// Assertion macros for the page bitmap allocator.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define PBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("page bitmap allocator check failed");

`define PBA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("page bitmap allocator check failed");

`else

`define PBA_ASSERT(label, clk, rst_n, prop)

`define PBA_ASSERT_NR(label, clk, prop)

`endif

`endif

[rtl/core/pba_pkg.sv]
// Shared constants, operation and status codes, and the controller/datapath
// command and status structures for the page bitmap allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  localparam int NUM_PAGES   = 32768;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = NUM_PAGES / WORD_BITS;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int WORD_IDX_W  = PAGE_W - BIT_IDX_W;
  localparam int LIMIT_W     = PAGE_W + 1;
  localparam int OFFSET_W    = 12;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 16;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int FOUND_W     = PAGE_W + OFFSET_W;

  localparam logic [WORD_BITS-1:0] ALL_USED = '1;
  localparam logic [LIMIT_W-1:0]   RAM_PAGES_RESET = LIMIT_W'(32768);

  localparam logic [OP_W-1:0] OP_CHECK      = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK_USED  = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC      = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE_RANGE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic clr;
    logic capture;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_walk;
    logic pend_done;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/pba_ctrl.sv]
// Controller state machine for the page bitmap allocator: clearing pass,
// request capture and the word walk. Depends on pba_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "page_bitmap_allocator_assert.svh"

module pba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pba_pkg::stat_t stat,
  output pba_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);
  import pba_pkg::*;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.need_walk) begin
          cmd.step  = 1'b1;
          state_nxt = S_WALK;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.pend_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `PBA_ASSERT(a_busy_tracks_state, clk, rst_n, busy_r == (state_r != S_IDLE))
  `PBA_ASSERT(a_result_when_idle, clk, rst_n, out_valid_r |-> !busy_r)
  `PBA_ASSERT(a_accept_dispatches, clk, rst_n, (start && !busy_r) |=> state_r == S_DISPATCH)
  `PBA_ASSERT(a_no_step_after_done, clk, rst_n, cmd.step |-> !stat.pend_done)

endmodule

`default_nettype wire

[rtl/core/pba_datapath.sv]
// Datapath for the page bitmap allocator: request decode, bitmap memory with a
// one-word read pipeline, range masks and the free-bit search. Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pba_pkg::cmd_t                 cmd,
  output pba_pkg::stat_t                stat,
  input  logic                          cfg_we,
  input  logic [pba_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic [pba_pkg::OP_W-1:0]      in_operation,
  input  logic [pba_pkg::ADDR_W-1:0]    in_address,
  input  logic [pba_pkg::COUNT_W-1:0]   in_count,
  output logic [pba_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_page_used,
  output logic [pba_pkg::FOUND_W-1:0]   out_found_address
);
  import pba_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  logic [LIMIT_W-1:0]    ram_pages_r;
  logic [OP_W-1:0]       op_r;
  logic [PAGE_W-1:0]     lo_page_r, hi_page_r;
  logic                  need_walk_r;
  logic [WORD_IDX_W-1:0] rd_word_r, pend_word_r;
  logic                  pend_valid_r;
  logic [WORD_BITS-1:0]  rd_data_r;
  logic [STATUS_W-1:0]   status_r;
  logic                  page_used_r;
  logic [FOUND_W-1:0]    found_r;

  logic [LIMIT_W-1:0]    limit;
  logic [PAGE_W-1:0]     start_page;
  logic                  misalign, start_oob, end_gt;
  logic [LIMIT_W:0]      end_page, limit_ext, free_end;
  logic [PAGE_W-1:0]     mark_hi, free_hi, alloc_hi;
  logic [STATUS_W-1:0]   dec_status;
  logic                  dec_walk;
  logic [PAGE_W-1:0]     dec_lo, dec_hi;

  logic [BIT_IDX_W-1:0]  lo_bit, hi_bit, hit_bit;
  logic [WORD_BITS-1:0]  mask, free_bits;
  logic                  alloc_hit;
  logic                  wr_en;
  logic [WORD_IDX_W-1:0] wr_addr;
  logic [WORD_BITS-1:0]  wr_data;

  assign limit      = (ram_pages_r > LIMIT_W'(NUM_PAGES)) ? LIMIT_W'(NUM_PAGES) : ram_pages_r;
  assign start_page = in_address[OFFSET_W +: PAGE_W];
  assign misalign   = |in_address[OFFSET_W-1:0];
  assign start_oob  = in_address[ADDR_W-1:OFFSET_W] >= (ADDR_W-OFFSET_W)'(limit);
  assign limit_ext  = (LIMIT_W+1)'(limit);
  assign end_page   = (LIMIT_W+1)'(start_page) + (LIMIT_W+1)'(in_count);
  assign end_gt     = end_page > limit_ext;
  assign free_end   = end_gt ? limit_ext : end_page;
  assign mark_hi    = PAGE_W'(end_page - (LIMIT_W+1)'(1));
  assign free_hi    = PAGE_W'(free_end - (LIMIT_W+1)'(1));
  assign alloc_hi   = PAGE_W'(limit - LIMIT_W'(1));

  always_comb begin
    dec_status = ST_OK;
    dec_walk   = 1'b0;
    dec_lo     = start_page;
    dec_hi     = start_page;
    if (in_operation > OP_FREE_RANGE) begin
      dec_status = ST_ERROR;
    end else if (in_operation == OP_ALLOC) begin
      dec_lo     = '0;
      dec_hi     = alloc_hi;
      dec_status = ST_ERROR;
      dec_walk   = (in_count == COUNT_W'(1)) && (limit != '0);
    end else if (misalign || start_oob) begin
      dec_status = ST_INVALID;
    end else if (in_operation == OP_CHECK) begin
      dec_walk = 1'b1;
    end else if (in_operation == OP_FREE_RANGE) begin
      dec_hi   = free_hi;
      dec_walk = (in_count != '0);
    end else if (end_gt) begin
      dec_status = ST_INVALID;
    end else begin
      dec_hi   = mark_hi;
      dec_walk = (in_count != '0);
    end
  end

  assign lo_bit = (pend_word_r == lo_page_r[PAGE_W-1:BIT_IDX_W]) ?
                  lo_page_r[BIT_IDX_W-1:0] : '0;
  assign hi_bit = (pend_word_r == hi_page_r[PAGE_W-1:BIT_IDX_W]) ?
                  hi_page_r[BIT_IDX_W-1:0] : '1;
  assign mask      = (ALL_USED << lo_bit) & (ALL_USED >> (~hi_bit));
  assign free_bits = ~rd_data_r & mask;
  assign alloc_hit = |free_bits;

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_word_r;
    wr_data = ALL_USED;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end else if (pend_valid_r) begin
      wr_addr = pend_word_r;
      case (op_r) inside
        OP_MARK_USED: begin
          wr_data = rd_data_r | mask;
          wr_en   = |mask;
        end
        OP_MARK_FREE, OP_FREE_RANGE: begin
          wr_data = rd_data_r & ~mask;
          wr_en   = |mask;
        end
        OP_ALLOC: begin
          wr_data = rd_data_r | (WORD_BITS'(1) << hit_bit);
          wr_en   = alloc_hit;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      rd_data_r <= mem[rd_word_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_pages_r  <= RAM_PAGES_RESET;
      rd_word_r    <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ram_pages_r <= cfg_wdata;
      end
      pend_valid_r <= cmd.step;
      if (cmd.capture) begin
        rd_word_r <= dec_lo[PAGE_W-1:BIT_IDX_W];
      end else if (cmd.clr || cmd.step) begin
        rd_word_r <= rd_word_r + WORD_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_word_r <= rd_word_r;
    end
    if (cmd.capture) begin
      op_r        <= in_operation;
      lo_page_r   <= dec_lo;
      hi_page_r   <= dec_hi;
      need_walk_r <= dec_walk;
      status_r    <= dec_status;
      page_used_r <= 1'b0;
      found_r     <= '0;
    end else if (pend_valid_r) begin
      if (op_r == OP_CHECK) begin
        page_used_r <= rd_data_r[lo_page_r[BIT_IDX_W-1:0]];
      end
      if (op_r == OP_ALLOC && alloc_hit) begin
        status_r <= ST_OK;
        found_r  <= {pend_word_r, hit_bit, OFFSET_W'(0)};
      end
    end
  end

  assign stat.clr_last  = (rd_word_r == WORD_IDX_W'(MAP_WORDS - 1));
  assign stat.need_walk = need_walk_r;
  assign stat.pend_done = pend_valid_r &&
                          ((pend_word_r == hi_page_r[PAGE_W-1:BIT_IDX_W]) ||
                           (op_r == OP_ALLOC && alloc_hit));

  assign out_status        = status_r;
  assign out_page_used     = page_used_r;
  assign out_found_address = found_r;

endmodule

`default_nettype wire

[rtl/core/page_bitmap_allocator.sv]
// Page bitmap allocator top level: one used bit per 4 KiB page, 1024 words of 32 bits.
// A request rejected at decode has its decode and then its result strobe registered; a
// walk reads one bitmap word per cycle into a register before the result strobe; an
// allocate walks up to ceil(min(ram_pages, 32768) / 32) words, stopping at a free page.
// A request is taken only once the last result is out; busy falls with the strobe.
// No receiver stall. After reset a clearing pass marks every page used while busy is high.
`timescale 1ns / 1ps
`default_nettype none

module page_bitmap_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pba_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [pba_pkg::OP_W-1:0]      in_operation,
  input  logic [pba_pkg::ADDR_W-1:0]    in_address,
  input  logic [pba_pkg::COUNT_W-1:0]   in_count,
  output logic                          out_valid,
  output logic [pba_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_page_used,
  output logic [pba_pkg::FOUND_W-1:0]   out_found_address
);
  import pba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pba_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .in_count          (in_count),
    .out_status        (out_status),
    .out_page_used     (out_page_used),
    .out_found_address (out_found_address)
  );

endmodule

`default_nettype wire

[dv/tb_page_bitmap_allocator.sv]
// Self-checking testbench for page_bitmap_allocator: directed table, then random phases
// over several managed page counts; each result is checked against a typed table reply
// or an in-bench bitmap predictor. Depends on pba_pkg and the page_bitmap_allocator RTL only.
`timescale 1ns / 1ps

module tb_page_bitmap_allocator;
  import pba_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                page_used;
    logic [FOUND_W-1:0]  found_address;
  } reply_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] cnt;
    logic               typed;
    reply_t             want;
  } request_row_t;

  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam reply_t R_OK      = '{ST_OK, 1'b0, '0};
  localparam reply_t R_USED    = '{ST_OK, 1'b1, '0};
  localparam reply_t R_INVALID = '{ST_INVALID, 1'b0, '0};
  localparam reply_t R_ERROR   = '{ST_ERROR, 1'b0, '0};

  localparam int NUM_DIRECTED = 26;
  localparam int NUM_PHASES   = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_operation = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic [COUNT_W-1:0]   in_count = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_page_used;
  logic [FOUND_W-1:0]   out_found_address;

  logic [WORD_BITS-1:0] used_bits [MAP_WORDS];
  logic [LIMIT_W-1:0]   managed_ram_pages;
  reply_t               alloc_replies [$];
  int                   fail_count = 0;

  request_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_CHECK,      32'h0000_0000, 16'd0,      1'b1, R_USED},
    '{OP_CHECK,      32'h0000_0001, 16'd0,      1'b1, R_INVALID},
    '{OP_CHECK,      32'hFFFF_F000, 16'd0,      1'b1, R_INVALID},
    '{OP_ALLOC,      32'h0000_0000, 16'd1,      1'b1, R_ERROR},
    '{OP_ALLOC,      32'h0000_0000, 16'd0,      1'b1, R_ERROR},
    '{OP_ALLOC,      32'hFFFF_FFFF, 16'hFFFF,   1'b1, R_ERROR},
    '{OP_MARK_FREE,  32'h0000_0000, 16'd0,      1'b1, R_OK},
    '{OP_MARK_FREE,  32'h0000_0000, 16'hFFFF,   1'b1, R_INVALID},
    '{OP_MARK_FREE,  32'h0000_0000, 16'h8000,   1'b1, R_OK},
    '{OP_CHECK,      32'h07FF_F000, 16'd0,      1'b1, R_OK},
    '{OP_MARK_USED,  32'h07FF_F000, 16'd1,      1'b1, R_OK},
    '{OP_CHECK,      32'h07FF_F000, 16'd0,      1'b1, R_USED},
    '{OP_MARK_USED,  32'h07FF_F000, 16'd2,      1'b1, R_INVALID},
    '{OP_MARK_USED,  32'h0800_0000, 16'd0,      1'b1, R_INVALID},
    '{OP_ALLOC,      32'h0000_0000, 16'd1,      1'b1, '{ST_OK, 1'b0, 27'h000_0000}},
    '{OP_ALLOC,      32'h0000_0000, 16'd1,      1'b1, '{ST_OK, 1'b0, 27'h000_1000}},
    '{OP_MARK_USED,  32'h0000_2000, 16'd40,     1'b0, R_OK},
    '{OP_ALLOC,      32'h0000_0000, 16'd1,      1'b0, R_OK},
    '{OP_FREE_RANGE, 32'h07FF_E000, 16'hFFFF,   1'b1, R_OK},
    '{OP_FREE_RANGE, 32'h0000_0800, 16'd1,      1'b1, R_INVALID},
    '{OP_FREE_RANGE, 32'h0800_0000, 16'd0,      1'b1, R_INVALID},
    '{OP_FREE_RANGE, 32'h0000_0000, 16'd0,      1'b1, R_OK},
    '{OP_RSVD_5,     32'h0000_0000, 16'd0,      1'b1, R_ERROR},
    '{OP_RSVD_6,     32'hFFFF_FFFF, 16'hFFFF,   1'b1, R_ERROR},
    '{OP_RSVD_7,     32'h5555_5000, 16'h1234,   1'b1, R_ERROR},
    '{OP_MARK_USED,  32'h0000_0000, 16'h8000,   1'b1, R_OK}
  };

  int phase_pages_lo [NUM_PHASES] = '{1, 0, 33, 64,   65535, 64,   32768, 1};
  int phase_pages_hi [NUM_PHASES] = '{1, 0, 33, 2048, 65535, 4096, 32768, 512};
  int phase_idle_pct [NUM_PHASES] = '{0, 74, 38, 0,   74,    38,   0,     74};
  int phase_requests [NUM_PHASES] = '{60, 40, 150, 350, 200, 350, 150, 250};

  page_bitmap_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_page_used     (out_page_used),
    .out_found_address (out_found_address)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reply_t apply_page_request(input logic [OP_W-1:0] op,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [COUNT_W-1:0] cnt);
    reply_t      r;
    int unsigned limit;
    int unsigned first;
    int unsigned last;
    int unsigned p;
    int unsigned w;
    int unsigned b;
    bit          hit;
    r = R_OK;
    hit = 1'b0;
    limit = (managed_ram_pages > NUM_PAGES) ? NUM_PAGES : managed_ram_pages;
    first = addr >> OFFSET_W;
    last = first + cnt;
    if (op <= OP_FREE_RANGE && op != OP_ALLOC &&
        (addr[OFFSET_W-1:0] != '0 || first >= limit)) begin
      r.status = ST_INVALID;
    end else begin
      case (op)
        OP_CHECK: begin
          r.page_used = used_bits[first / WORD_BITS][first % WORD_BITS];
        end
        OP_MARK_USED, OP_MARK_FREE: begin
          if (last > limit) begin
            r.status = ST_INVALID;
          end else begin
            for (p = first; p < last; p++)
              used_bits[p / WORD_BITS][p % WORD_BITS] = (op == OP_MARK_USED);
          end
        end
        OP_ALLOC: begin
          r.status = ST_ERROR;
          if (cnt == 1) begin
            for (w = 0; w * WORD_BITS < limit && !hit; w++) begin
              for (b = 0; b < WORD_BITS && !hit; b++) begin
                p = w * WORD_BITS + b;
                if (p < limit && !used_bits[w][b]) begin
                  hit = 1'b1;
                  used_bits[w][b] = 1'b1;
                  r.status = ST_OK;
                  r.found_address = FOUND_W'(p << OFFSET_W);
                end
              end
            end
          end
        end
        OP_FREE_RANGE: begin
          for (p = first; p < last && p < limit; p++)
            used_bits[p / WORD_BITS][p % WORD_BITS] = 1'b0;
        end
        default: begin
          r.status = ST_ERROR;
        end
      endcase
    end
    return r;
  endfunction

  task automatic issue_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [COUNT_W-1:0] cnt, input logic typed,
                               input reply_t want);
    reply_t predicted;
    in_operation <= op;
    in_address <= addr;
    in_count <= cnt;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_page_request(op, addr, cnt);
    alloc_replies.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (alloc_replies.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_ram_pages(input logic [LIMIT_W-1:0] pages);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= pages;
    @(posedge clk);
    cfg_we <= 1'b0;
    managed_ram_pages = pages;
  endtask

  task automatic pick_random_request(output logic [OP_W-1:0] op,
                                     output logic [ADDR_W-1:0] addr,
                                     output logic [COUNT_W-1:0] cnt);
    int unsigned limit;
    int unsigned page;
    int unsigned room;
    int unsigned sel;
    limit = (managed_ram_pages > NUM_PAGES) ? NUM_PAGES : managed_ram_pages;
    sel = $urandom_range(0, 99);
    if (sel < 24) op = OP_CHECK;
    else if (sel < 44) op = OP_MARK_USED;
    else if (sel < 64) op = OP_MARK_FREE;
    else if (sel < 86) op = OP_ALLOC;
    else if (sel < 97) op = OP_FREE_RANGE;
    else op = OP_W'($urandom_range(5, 7));

    page = (limit == 0) ? 0 : $urandom_range(0, limit - 1);
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      addr = $urandom();
    end else if (sel < 10) begin
      addr = ADDR_W'($urandom_range(0, limit + 40) << OFFSET_W);
    end else if (sel < 13) begin
      addr = ADDR_W'(page << OFFSET_W) | ADDR_W'($urandom_range(1, 4095));
    end else begin
      addr = ADDR_W'(page << OFFSET_W);
    end

    page = addr >> OFFSET_W;
    room = (page < limit) ? limit - page : 0;
    sel = $urandom_range(0, 99);
    if (op == OP_ALLOC && sel < 92) cnt = 16'd1;
    else if (sel < 55) cnt = COUNT_W'($urandom_range(0, 8));
    else if (sel < 75) cnt = COUNT_W'($urandom_range(0, 64));
    else if (sel < 85) cnt = COUNT_W'(room);
    else if (sel < 90) cnt = COUNT_W'(room + 1);
    else if (sel < 94) cnt = COUNT_W'($urandom());
    else cnt = COUNT_W'($urandom_range(0, room));
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (alloc_replies.size() == 0) begin
        $display("%0t: result with none expected: status %0d page_used %0d found %h",
                 $time, out_status, out_page_used, out_found_address);
        fail_count++;
      end else begin
        want = alloc_replies.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          fail_count++;
        end
        if (out_page_used !== want.page_used) begin
          $display("%0t: page_used mismatch: expected %0d, actual %0d",
                   $time, want.page_used, out_page_used);
          fail_count++;
        end
        if (out_found_address !== want.found_address) begin
          $display("%0t: found_address mismatch: expected %h, actual %h",
                   $time, want.found_address, out_found_address);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] cnt;
    int                 pause_at;
    int                 idle_pct;
    for (int w = 0; w < MAP_WORDS; w++) used_bits[w] = ALL_USED;
    managed_ram_pages = RAM_PAGES_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].cnt,
                    directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_ram_pages(LIMIT_W'($urandom_range(phase_pages_lo[ph], phase_pages_hi[ph])));
      idle_pct = phase_idle_pct[ph];
      pause_at = $urandom_range(1, phase_requests[ph] - 1);
      for (int n = 0; n < phase_requests[ph]; n++) begin
        if (n == pause_at) wait_idle();
        pick_random_request(op, addr, cnt);
        issue_request(op, addr, cnt, 1'b0, R_OK);
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && alloc_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
